// File: hdl/bccp_pkg.sv
// Shared types and codes for the XOR-checked frame parser.
// Used by bccp_core, bccp_outbuf and bcc_checked_frame_parser_unit; no dependencies.
`default_nettype none

package bccp_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_write;
    logic [7:0]  device_type;
    logic [23:0] device_id;
    logic [15:0] command_code;
    logic [7:0]  packet_id;
    logic [7:0]  payload_length;
    logic [7:0]  payload_data;
  } rec_t;

endpackage

`default_nettype wire

// File: hdl/bcc_checked_frame_parser_unit.sv
// XOR-checked frame parser: one received byte in per cycle unless byte_stall holds it, at most one record out per byte.
// Hunts for '#' then 'R'/'W', streams payload bytes, and ends each frame with a record
// flagged good or bad by the XOR check (bad length also rejects). Each byte is handled in
// the cycle it is accepted, so the rate is one byte per cycle while byte_stall is low;
// each record it causes is registered. A two-entry output buffer (register plus skid)
// absorbs a stalled record side; byte_stall rises only when both entries hold an item.
// Depends on bccp_pkg, bccp_core and bccp_outbuf.
`default_nettype none

module bcc_checked_frame_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        buffer_end,
  output logic             record_valid,
  input  wire logic        record_stall,
  output logic [1:0]       record_kind,
  output logic             is_write,
  output logic [7:0]       device_type,
  output logic [23:0]      device_id,
  output logic [15:0]      command_code,
  output logic [7:0]       packet_id,
  output logic [7:0]       payload_length,
  output logic [7:0]       payload_data
);

  logic           accept;
  logic           res_valid;
  bccp_pkg::rec_t res;
  bccp_pkg::rec_t out_rec;
  logic           full;

  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = full;

  bccp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .buffer_end (buffer_end),
    .res_valid  (res_valid),
    .res        (res)
  );

  bccp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_rec  (res),
    .full      (full),
    .out_valid (record_valid),
    .out_stall (record_stall),
    .out_rec   (out_rec)
  );

  assign record_kind    = out_rec.kind;
  assign is_write       = out_rec.is_write;
  assign device_type    = out_rec.device_type;
  assign device_id      = out_rec.device_id;
  assign command_code   = out_rec.command_code;
  assign packet_id      = out_rec.packet_id;
  assign payload_length = out_rec.payload_length;
  assign payload_data   = out_rec.payload_data;

endmodule

`default_nettype wire

// File: hdl/bccp_core.sv
// Frame parser state: start hunt, header capture, XOR check and record building.
// One accepted byte updates the state; the record it causes is combinational.
// Depends on bccp_pkg.
`default_nettype none

module bccp_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          buffer_end,
  output logic               res_valid,
  output bccp_pkg::rec_t     res
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HASH    = 2'd1,
    PH_FRAME   = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  localparam logic [7:0] START_CH = 8'h23;
  localparam logic [7:0] READ_CH  = 8'h52;
  localparam logic [7:0] WRITE_CH = 8'h57;
  localparam logic [7:0] LEN_MIN  = 8'd7;
  localparam logic [7:0] LEN_MAX  = 8'd251;

  phase_t      phase, phase_next;
  logic [7:0]  pos, pos_next;
  logic        frame_is_write, frame_is_write_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  length_byte, length_byte_next;
  logic [23:0] frame_device_id, frame_device_id_next;
  logic [15:0] frame_command, frame_command_next;
  logic [7:0]  check_acc, check_acc_next;
  logic [7:0]  previous_byte;

  logic [8:0]  pos9;
  logic [8:0]  len9;
  logic        good;

  assign pos9 = {1'b0, pos};
  assign len9 = {1'b0, length_byte};
  assign good = (check_acc == rx_byte);

  always_comb begin
    phase_next           = phase;
    pos_next             = pos;
    frame_is_write_next  = frame_is_write;
    frame_type_next      = frame_type;
    length_byte_next     = length_byte;
    frame_device_id_next = frame_device_id;
    frame_command_next   = frame_command;
    check_acc_next       = check_acc;
    res_valid            = 1'b0;
    res                  = '0;
    res.is_write         = frame_is_write;
    res.device_type      = frame_type;
    res.device_id        = frame_device_id;
    res.command_code     = frame_command;
    res.payload_length   = length_byte - LEN_MIN;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == START_CH) begin
          phase_next = PH_HASH;
        end
      end
      PH_HASH: begin
        if (rx_byte == READ_CH || rx_byte == WRITE_CH) begin
          phase_next           = PH_FRAME;
          pos_next             = 8'd2;
          frame_is_write_next  = (rx_byte == WRITE_CH);
          frame_type_next      = '0;
          length_byte_next     = '0;
          frame_device_id_next = '0;
          frame_command_next   = '0;
          check_acc_next       = START_CH ^ rx_byte;
        end else if (rx_byte != START_CH) begin
          phase_next = PH_HUNT;
        end
      end
      PH_FRAME: begin
        // default: fold the byte into the check and advance
        check_acc_next = check_acc ^ rx_byte;
        pos_next       = pos + 8'd1;
        priority if (pos == 8'd2) begin
          frame_type_next = rx_byte;
        end else if (pos == 8'd3) begin
          length_byte_next = rx_byte;
          if (rx_byte < LEN_MIN || rx_byte > LEN_MAX) begin
            res_valid          = 1'b1;
            res.kind           = bccp_pkg::KIND_BAD;
            res.device_id      = '0;
            res.command_code   = '0;
            res.payload_length = '0;
            phase_next         = PH_DISCARD;
            check_acc_next     = check_acc;
            pos_next           = pos;
          end
        end else if (pos >= 8'd4 && pos <= 8'd6) begin
          frame_device_id_next = {frame_device_id[15:0], rx_byte};
        end else if (pos == 8'd8 || pos == 8'd9) begin
          frame_command_next = {frame_command[7:0], rx_byte};
        end else if (pos >= 8'd10 && pos9 <= len9 + 9'd2) begin
          res_valid        = 1'b1;
          res.kind         = bccp_pkg::KIND_PAYLOAD;
          res.payload_data = rx_byte;
        end else if (pos9 == len9 + 9'd4) begin
          res_valid      = 1'b1;
          res.kind       = good ? bccp_pkg::KIND_GOOD : bccp_pkg::KIND_BAD;
          res.packet_id  = previous_byte;
          phase_next     = good ? PH_HUNT : PH_DISCARD;
          pos_next       = '0;
          check_acc_next = check_acc;
        end else begin
          // skipped byte and packet id only feed the check
        end
      end
      PH_DISCARD: begin
      end
      default: begin
      end
    endcase

    if (buffer_end) begin
      phase_next = PH_HUNT;
      pos_next   = '0;
    end
    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      pos             <= '0;
      frame_is_write  <= 1'b0;
      frame_type      <= '0;
      length_byte     <= '0;
      frame_device_id <= '0;
      frame_command   <= '0;
      check_acc       <= '0;
      previous_byte   <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      pos             <= pos_next;
      frame_is_write  <= frame_is_write_next;
      frame_type      <= frame_type_next;
      length_byte     <= length_byte_next;
      frame_device_id <= frame_device_id_next;
      frame_command   <= frame_command_next;
      check_acc       <= check_acc_next;
      previous_byte   <= rx_byte;
    end
  end

`ifndef SYNTHESIS
  a_hunt_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT || phase == PH_HASH) |-> pos == 8'd0)
    else $error("position not cleared outside a frame");

  a_buffer_end_resync: assert property (@(posedge clk) disable iff (rst)
    accept && buffer_end |=> phase == PH_HUNT && pos == 8'd0)
    else $error("buffer end did not return parser to hunting");

  a_good_back_to_hunt: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == bccp_pkg::KIND_GOOD |=> phase == PH_HUNT)
    else $error("accepted frame did not return to hunting");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.kind == bccp_pkg::KIND_PAYLOAD || res.kind == bccp_pkg::KIND_GOOD
                   || res.kind == bccp_pkg::KIND_BAD))
    else $error("illegal record kind");
`endif

endmodule

`default_nettype wire

// File: hdl/bccp_outbuf.sv
// Result register with one skid entry, so a waiting record blocks the byte side only once the skid entry is full.
// Depends on bccp_pkg.
`default_nettype none

module bccp_outbuf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bccp_pkg::rec_t  push_rec,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output bccp_pkg::rec_t       out_rec
);

  logic           skid_valid;
  bccp_pkg::rec_t skid_rec;
  logic           take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_rec <= skid_valid ? skid_rec : push_rec;
    end
    if (out_valid && !take && push) begin
      skid_rec <= push_rec;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("item pushed while skid entry occupied");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && take |=> !skid_valid && out_valid)
    else $error("skid entry not moved to output register");
`endif

endmodule

`default_nettype wire
